FILE: sv/smalu_pkg.sv
package smalu_pkg;

  // default configuration
  localparam int DEF_STACK_DEPTH = 64;
  localparam int DEF_DATA_WIDTH  = 32;

  // fixed field widths at the ports
  localparam int CMD_W    = 4;
  localparam int OPND_W   = 32;
  localparam int TOP_W    = 32;
  localparam int DEPTH_W  = 7;
  localparam int STATUS_W = 2;

  // microprogram counter
  localparam int UPC_W = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_CONST = 4'd0,
    CMD_ADD   = 4'd1,
    CMD_SUB   = 4'd2,
    CMD_MUL   = 4'd3,
    CMD_DIV   = 4'd4,
    CMD_MAX   = 4'd5,
    CMD_MIN   = 4'd6,
    CMD_NEG   = 4'd7,
    CMD_DUP   = 4'd8,
    CMD_SWAP  = 4'd9
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_UNDER = 2'd1,
    ST_OVER  = 2'd2,
    ST_DIVZ  = 2'd3
  } status_t;

  // jump conditions
  typedef enum logic [2:0] {
    C_NONE,
    C_EMPTY,
    C_LT2,
    C_FULL,
    C_DIVZ,
    C_MDBUSY
  } cond_t;

  typedef enum logic [1:0] {
    MW_NONE,
    MW_PUSH,
    MW_NOS
  } mem_wr_t;

  typedef enum logic [2:0] {
    TS_KEEP,
    TS_OPND,
    TS_NEG,
    TS_ALU,
    TS_NOS,
    TS_MD
  } tos_sel_t;

  typedef enum logic [1:0] {
    CO_KEEP,
    CO_INC,
    CO_DEC
  } cnt_op_t;

  typedef struct packed {
    cond_t             cond;
    logic [UPC_W-1:0]  target;
    logic              mem_rd;
    mem_wr_t           mem_wr;
    tos_sel_t          tos_sel;
    cnt_op_t           cnt_op;
    logic              md_start;
    logic              done;
    status_t           status;
  } uword_t;

  typedef struct packed {
    logic   en;
    uword_t uw;
  } ctl_t;

  typedef struct packed {
    logic empty;
    logic lt2;
    logic full;
    logic divz;
    logic md_busy;
    logic res_blocked;
  } flags_t;

  // microprogram entry points and step addresses
  localparam logic [UPC_W-1:0] UA_CONST     = 5'd0;
  localparam logic [UPC_W-1:0] UA_CONST_DO  = 5'd1;
  localparam logic [UPC_W-1:0] UA_DUP       = 5'd2;
  localparam logic [UPC_W-1:0] UA_DUP_FULL  = 5'd3;
  localparam logic [UPC_W-1:0] UA_DUP_DO    = 5'd4;
  localparam logic [UPC_W-1:0] UA_NEG       = 5'd5;
  localparam logic [UPC_W-1:0] UA_NEG_DO    = 5'd6;
  localparam logic [UPC_W-1:0] UA_SWAP      = 5'd7;
  localparam logic [UPC_W-1:0] UA_SWAP_DO   = 5'd8;
  localparam logic [UPC_W-1:0] UA_ARITH     = 5'd9;
  localparam logic [UPC_W-1:0] UA_ARITH_DO  = 5'd10;
  localparam logic [UPC_W-1:0] UA_MD        = 5'd11;
  localparam logic [UPC_W-1:0] UA_MD_CHK    = 5'd12;
  localparam logic [UPC_W-1:0] UA_MD_GO     = 5'd13;
  localparam logic [UPC_W-1:0] UA_MD_WAIT   = 5'd14;
  localparam logic [UPC_W-1:0] UA_MD_DO     = 5'd15;
  localparam logic [UPC_W-1:0] UA_ERR_UNDER = 5'd16;
  localparam logic [UPC_W-1:0] UA_ERR_OVER  = 5'd17;
  localparam logic [UPC_W-1:0] UA_ERR_DIVZ  = 5'd18;
  localparam logic [UPC_W-1:0] UA_NOP       = 5'd19;

  function automatic logic [UPC_W-1:0] dispatch(input logic [CMD_W-1:0] cmd);
    logic [UPC_W-1:0] a;
    case (cmd)
      CMD_CONST:                         a = UA_CONST;
      CMD_DUP:                           a = UA_DUP;
      CMD_NEG:                           a = UA_NEG;
      CMD_SWAP:                          a = UA_SWAP;
      CMD_ADD, CMD_SUB, CMD_MAX, CMD_MIN: a = UA_ARITH;
      CMD_MUL, CMD_DIV:                  a = UA_MD;
      default:                           a = UA_NOP;
    endcase
    return a;
  endfunction

  // control store
  function automatic uword_t ucode_rom(input logic [UPC_W-1:0] a);
    uword_t w;
    w = '0;
    case (a)
      UA_CONST: begin
        w.cond = C_FULL;  w.target = UA_ERR_OVER;
      end
      UA_CONST_DO: begin
        w.mem_wr = MW_PUSH; w.tos_sel = TS_OPND; w.cnt_op = CO_INC; w.done = 1'b1;
      end
      UA_DUP: begin
        w.cond = C_EMPTY; w.target = UA_ERR_UNDER;
      end
      UA_DUP_FULL: begin
        w.cond = C_FULL;  w.target = UA_ERR_OVER;
      end
      UA_DUP_DO: begin
        w.mem_wr = MW_PUSH; w.cnt_op = CO_INC; w.done = 1'b1;
      end
      UA_NEG: begin
        w.cond = C_EMPTY; w.target = UA_ERR_UNDER;
      end
      UA_NEG_DO: begin
        w.tos_sel = TS_NEG; w.done = 1'b1;
      end
      UA_SWAP: begin
        w.cond = C_LT2;   w.target = UA_ERR_UNDER; w.mem_rd = 1'b1;
      end
      UA_SWAP_DO: begin
        w.mem_wr = MW_NOS; w.tos_sel = TS_NOS; w.done = 1'b1;
      end
      UA_ARITH: begin
        w.cond = C_LT2;   w.target = UA_ERR_UNDER; w.mem_rd = 1'b1;
      end
      UA_ARITH_DO: begin
        w.tos_sel = TS_ALU; w.cnt_op = CO_DEC; w.done = 1'b1;
      end
      UA_MD: begin
        w.cond = C_LT2;   w.target = UA_ERR_UNDER; w.mem_rd = 1'b1;
      end
      UA_MD_CHK: begin
        w.cond = C_DIVZ;  w.target = UA_ERR_DIVZ;
      end
      UA_MD_GO: begin
        w.md_start = 1'b1;
      end
      UA_MD_WAIT: begin
        w.cond = C_MDBUSY; w.target = UA_MD_WAIT;
      end
      UA_MD_DO: begin
        w.tos_sel = TS_MD; w.cnt_op = CO_DEC; w.done = 1'b1;
      end
      UA_ERR_UNDER: begin
        w.done = 1'b1; w.status = ST_UNDER;
      end
      UA_ERR_OVER: begin
        w.done = 1'b1; w.status = ST_OVER;
      end
      UA_ERR_DIVZ: begin
        w.done = 1'b1; w.status = ST_DIVZ;
      end
      default: begin
        w.done = 1'b1;
      end
    endcase
    return w;
  endfunction

endpackage

FILE: sv/smalu_seq.sv
module smalu_seq (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cmd_valid,
  output logic                                cmd_ready,
  input  logic [smalu_pkg::CMD_W-1:0]         command,
  input  smalu_pkg::flags_t                   flags,
  output smalu_pkg::ctl_t                     ctl
);

  logic                         busy;
  logic [smalu_pkg::UPC_W-1:0]  upc;
  smalu_pkg::uword_t            uw;
  logic                         cond_true;
  logic                         stall;

  assign uw = smalu_pkg::ucode_rom(upc);

  always_comb begin
    case (uw.cond)
      smalu_pkg::C_EMPTY:  cond_true = flags.empty;
      smalu_pkg::C_LT2:    cond_true = flags.lt2;
      smalu_pkg::C_FULL:   cond_true = flags.full;
      smalu_pkg::C_DIVZ:   cond_true = flags.divz;
      smalu_pkg::C_MDBUSY: cond_true = flags.md_busy;
      default:             cond_true = 1'b0;
    endcase
  end

  // a finishing step waits while the result register is still occupied
  assign stall     = uw.done && flags.res_blocked;
  assign ctl.en    = busy && !stall;
  assign ctl.uw    = uw;
  assign cmd_ready = !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      upc  <= '0;
    end else if (!busy) begin
      if (cmd_valid) begin
        busy <= 1'b1;
        upc  <= smalu_pkg::dispatch(command);
      end
    end else if (!stall) begin
      if (uw.done) begin
        busy <= 1'b0;
      end else if (cond_true) begin
        upc <= uw.target;
      end else begin
        upc <= upc + smalu_pkg::UPC_W'(1);
      end
    end
  end

`ifndef SYNTHESIS
  a_busy_ends_on_done: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) && !$past(rst) |-> $past(ctl.en && uw.done))
    else $error("sequencer left busy without a finishing step");
`endif

endmodule

FILE: sv/smalu_muldiv.sv
module smalu_muldiv #(
  parameter int DATA_WIDTH = smalu_pkg::DEF_DATA_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic                  is_div,
  input  logic [DATA_WIDTH-1:0] a,
  input  logic [DATA_WIDTH-1:0] b,
  output logic                  busy,
  output logic [DATA_WIDTH-1:0] result
);

  localparam int CNT_W = $clog2(DATA_WIDTH + 1);

  logic [CNT_W-1:0]      cnt;
  logic                  div_mode;
  logic                  neg_q;
  logic [DATA_WIDTH-1:0] acc;   // product or partial remainder
  logic [DATA_WIDTH-1:0] x;     // multiplicand or quotient/dividend
  logic [DATA_WIDTH-1:0] y;     // multiplier or divisor magnitude

  logic [DATA_WIDTH-1:0] mag_a;
  logic [DATA_WIDTH-1:0] mag_b;
  logic [DATA_WIDTH:0]   rem_sh;
  logic [DATA_WIDTH:0]   trial;

  assign mag_a  = a[DATA_WIDTH-1] ? -a : a;
  assign mag_b  = b[DATA_WIDTH-1] ? -b : b;
  assign rem_sh = {acc, x[DATA_WIDTH-1]};
  assign trial  = rem_sh - {1'b0, y};

  assign busy   = (cnt != '0);
  assign result = div_mode ? (neg_q ? -x : x) : acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CNT_W'(DATA_WIDTH);
    end else if (busy) begin
      cnt <= cnt - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      div_mode <= is_div;
      neg_q    <= a[DATA_WIDTH-1] ^ b[DATA_WIDTH-1];
      acc      <= '0;
      x        <= is_div ? mag_a : a;
      y        <= is_div ? mag_b : b;
    end else if (busy) begin
      if (div_mode) begin
        // restoring step, one quotient bit
        if (!trial[DATA_WIDTH]) begin
          acc <= trial[DATA_WIDTH-1:0];
          x   <= {x[DATA_WIDTH-2:0], 1'b1};
        end else begin
          acc <= rem_sh[DATA_WIDTH-1:0];
          x   <= {x[DATA_WIDTH-2:0], 1'b0};
        end
      end else begin
        // shift-add, low bits only
        acc <= acc + (y[0] ? x : '0);
        x   <= x << 1;
        y   <= y >> 1;
      end
    end
  end

endmodule

FILE: sv/smalu_dpath.sv
module smalu_dpath #(
  parameter int STACK_DEPTH = smalu_pkg::DEF_STACK_DEPTH,
  parameter int DATA_WIDTH  = smalu_pkg::DEF_DATA_WIDTH
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                accept,
  input  logic [smalu_pkg::CMD_W-1:0]         command,
  input  logic signed [smalu_pkg::OPND_W-1:0] operand,
  input  smalu_pkg::ctl_t                     ctl,
  input  logic                                md_busy,
  input  logic [DATA_WIDTH-1:0]               md_result,
  output logic                                md_start,
  output logic                                md_is_div,
  output logic [DATA_WIDTH-1:0]               md_a,
  output logic [DATA_WIDTH-1:0]               md_b,
  output smalu_pkg::flags_t                   flags,
  input  logic                                res_ready,
  output logic                                res_valid,
  output logic signed [smalu_pkg::TOP_W-1:0]  top_value,
  output logic [smalu_pkg::DEPTH_W-1:0]       depth,
  output logic [smalu_pkg::STATUS_W-1:0]      status
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  logic [smalu_pkg::CMD_W-1:0]         cmd_q;
  logic signed [smalu_pkg::OPND_W-1:0] opnd_q;
  logic [CW-1:0]                       count;
  logic [CW-1:0]                       count_next;
  logic [DATA_WIDTH-1:0]               tos;
  logic [DATA_WIDTH-1:0]               tos_next;
  logic [DATA_WIDTH-1:0]               nos_q;
  logic [DATA_WIDTH-1:0]               stack_store [STACK_DEPTH];

  logic [CW-1:0]                       idx_push;
  logic [CW-1:0]                       idx_nos;
  logic signed [DATA_WIDTH-1:0]        opnd_ext;
  logic [DATA_WIDTH-1:0]               alu_res;
  logic                                a_lt_b;

  assign idx_push = count - CW'(1);
  assign idx_nos  = count - CW'(2);
  assign opnd_ext = DATA_WIDTH'(opnd_q);
  assign a_lt_b   = $signed(tos) < $signed(nos_q);

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q  <= command;
      opnd_q <= operand;
    end
  end

  // top is a, next is b
  always_comb begin
    case (cmd_q)
      smalu_pkg::CMD_ADD: alu_res = tos + nos_q;
      smalu_pkg::CMD_SUB: alu_res = tos - nos_q;
      smalu_pkg::CMD_MAX: alu_res = a_lt_b ? nos_q : tos;
      default:            alu_res = a_lt_b ? tos : nos_q;
    endcase
  end

  always_comb begin
    case (ctl.uw.tos_sel)
      smalu_pkg::TS_OPND: tos_next = opnd_ext;
      smalu_pkg::TS_NEG:  tos_next = -tos;
      smalu_pkg::TS_ALU:  tos_next = alu_res;
      smalu_pkg::TS_NOS:  tos_next = nos_q;
      smalu_pkg::TS_MD:   tos_next = md_result;
      default:            tos_next = tos;
    endcase
  end

  always_comb begin
    case (ctl.uw.cnt_op)
      smalu_pkg::CO_INC: count_next = count + CW'(1);
      smalu_pkg::CO_DEC: count_next = count - CW'(1);
      default:           count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctl.en) begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      tos <= tos_next;
    end
  end

  // stack below the top; the top itself lives in tos
  always_ff @(posedge clk) begin
    if (ctl.en) begin
      if (ctl.uw.mem_wr == smalu_pkg::MW_PUSH && count != '0) begin
        stack_store[idx_push[AW-1:0]] <= tos;
      end else if (ctl.uw.mem_wr == smalu_pkg::MW_NOS) begin
        stack_store[idx_nos[AW-1:0]] <= tos;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en && ctl.uw.mem_rd) begin
      nos_q <= stack_store[idx_nos[AW-1:0]];
    end
  end

  assign md_start  = ctl.en && ctl.uw.md_start;
  assign md_is_div = (cmd_q == smalu_pkg::CMD_DIV);
  assign md_a      = tos;
  assign md_b      = nos_q;

  assign flags.empty       = (count == '0);
  assign flags.lt2         = (count < CW'(2));
  assign flags.full        = (count >= CW'(STACK_DEPTH));
  assign flags.divz        = (cmd_q == smalu_pkg::CMD_DIV) && (nos_q == '0);
  assign flags.md_busy     = md_busy;
  assign flags.res_blocked = res_valid && !res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (ctl.en && ctl.uw.done) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en && ctl.uw.done) begin
      top_value <= (count_next != '0) ? smalu_pkg::TOP_W'($signed(tos_next)) : '0;
      depth     <= smalu_pkg::DEPTH_W'(count_next);
      status    <= ctl.uw.status;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(STACK_DEPTH))
    else $error("stack count above depth");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    ctl.en && ctl.uw.cnt_op == smalu_pkg::CO_INC |-> !flags.full)
    else $error("push on a full stack");

  a_no_pop_short: assert property (@(posedge clk) disable iff (rst)
    ctl.en && ctl.uw.cnt_op == smalu_pkg::CO_DEC |-> !flags.lt2)
    else $error("pop with fewer than two values");

  a_md_done: assert property (@(posedge clk) disable iff (rst)
    ctl.en && ctl.uw.tos_sel == smalu_pkg::TS_MD |-> !md_busy)
    else $error("mul/div result taken while unit busy");
`endif

endmodule

FILE: sv/stack_machine_alu_top.sv
// integer stack machine: one instruction per command transaction, one result
// transaction per instruction
// command channel: cmd_valid/cmd_ready carry command (0 CONST .. 9 SWAP) and
//   operand (pushed by CONST only); codes 10 to 15 are a no-op
// result channel: res_valid/res_ready carry top_value (0 on an empty stack),
//   depth and status (ok, underflow, overflow, divide by zero); on an error
//   the stack is left as it was
// sequencing: a microcoded sequencer walks a short program for each command;
//   MUL and DIV run longest, iterating in the shared shift-add / restoring
//   divide unit, which sets the worst case; cmd_ready is high only between
//   instructions, so a new command is not taken until the current program
//   has finished
// the result is registered and appears the cycle after the final step
// stall: while a result waits for res_ready the next instruction still runs,
//   holding only at its final step until the result register frees
// reset: synchronous, clears the sequencer, the stack count and res_valid;
//   stack entries need no clearing since only pushed entries are ever used
module stack_machine_alu_top #(
  parameter int STACK_DEPTH = smalu_pkg::DEF_STACK_DEPTH,
  parameter int DATA_WIDTH  = smalu_pkg::DEF_DATA_WIDTH
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cmd_valid,
  output logic                                cmd_ready,
  input  logic [smalu_pkg::CMD_W-1:0]         command,
  input  logic signed [smalu_pkg::OPND_W-1:0] operand,
  output logic                                res_valid,
  input  logic                                res_ready,
  output logic signed [smalu_pkg::TOP_W-1:0]  top_value,
  output logic [smalu_pkg::DEPTH_W-1:0]       depth,
  output logic [smalu_pkg::STATUS_W-1:0]      status
);

  smalu_pkg::ctl_t       ctl;
  smalu_pkg::flags_t     flags;
  logic                  accept;
  logic                  md_start;
  logic                  md_is_div;
  logic                  md_busy;
  logic [DATA_WIDTH-1:0] md_a;
  logic [DATA_WIDTH-1:0] md_b;
  logic [DATA_WIDTH-1:0] md_result;

  // command transaction completes here
  assign accept = cmd_valid && cmd_ready;

  // step counter and control store
  smalu_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .command   (command),
    .flags     (flags),
    .ctl       (ctl)
  );

  // stack memory, top-of-stack register, alu and result register
  smalu_dpath #(
    .STACK_DEPTH (STACK_DEPTH),
    .DATA_WIDTH  (DATA_WIDTH)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .command   (command),
    .operand   (operand),
    .ctl       (ctl),
    .md_busy   (md_busy),
    .md_result (md_result),
    .md_start  (md_start),
    .md_is_div (md_is_div),
    .md_a      (md_a),
    .md_b      (md_b),
    .flags     (flags),
    .res_ready (res_ready),
    .res_valid (res_valid),
    .top_value (top_value),
    .depth     (depth),
    .status    (status)
  );

  // one bit per cycle multiply / divide
  smalu_muldiv #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_muldiv (
    .clk    (clk),
    .rst    (rst),
    .start  (md_start),
    .is_div (md_is_div),
    .a      (md_a),
    .b      (md_b),
    .busy   (md_busy),
    .result (md_result)
  );

endmodule
